FILE: design/sbb_pkg.sv
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared types and constants of the 2bpp scaled sprite blitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sbb_pkg;

  localparam int SBB_MAX_SIDE  = 128;
  localparam int SBB_MAX_SCALE = 4;
  localparam int SBB_QDEPTH    = 2;

  localparam logic [1:0] SBB_SHADE_CLEAR = 2'd3;
  localparam logic [2:0] SBB_PIX_NONE    = 3'd4;

  typedef enum logic [2:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_WIDTH,
    REG_HEIGHT,
    REG_SCALE,
    REG_COLOR0,
    REG_COLOR1,
    REG_COLOR2
  } sbb_reg_e;

  typedef struct packed {
    logic signed [11:0] origin_x;
    logic signed [11:0] origin_y;
    logic [7:0]         sprite_width;
    logic [7:0]         sprite_height;
    logic [2:0]         scale;
    logic [15:0]        color0;
    logic [15:0]        color1;
    logic [15:0]        color2;
  } sbb_cfg_t;

  // one queued byte: which pixels draw, their shades and the block origin
  typedef struct packed {
    logic [3:0]  draw;
    logic [7:0]  shades;
    logic [12:0] base_x;
    logic [12:0] base_y;
    logic [2:0]  scale;
  } sbb_desc_t;

endpackage

FILE: design/sbb_front.sv
// ----------------------------------------------------------------------------
// sbb_front
// Accepts sprite bytes, tracks row and byte position, marks the pixels that
// draw and queues a descriptor for each byte that draws anything.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbb_front import sbb_pkg::*; #(
  parameter int MAX_SIDE  = SBB_MAX_SIDE,
  parameter int MAX_SCALE = SBB_MAX_SCALE
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sbb_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] sprite_byte_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output sbb_desc_t  q_desc_o
);

  localparam int RW = $clog2(MAX_SIDE);
  localparam int BW = $clog2((MAX_SIDE + 3) / 4);
  localparam int CW = ((RW > 8) ? RW : 8) + 2;

  logic [RW-1:0] row_q, row_d;
  logic [BW-1:0] byte_q, byte_d;
  logic [CW-1:0] w_c, h_c, row_len, byte_nx, row_nx;
  logic [2:0]    s_c;
  logic [3:0]    draw;
  logic          accept;

  always_comb begin
    logic [CW-1:0] sx;
    logic [1:0]    shade;
    if (cfg_i.sprite_width == 8'd0) w_c = CW'(1);
    else if (CW'(cfg_i.sprite_width) > CW'(MAX_SIDE)) w_c = CW'(MAX_SIDE);
    else w_c = CW'(cfg_i.sprite_width);
    if (cfg_i.sprite_height == 8'd0) h_c = CW'(1);
    else if (CW'(cfg_i.sprite_height) > CW'(MAX_SIDE)) h_c = CW'(MAX_SIDE);
    else h_c = CW'(cfg_i.sprite_height);
    if (cfg_i.scale == 3'd0) s_c = 3'd1;
    else if (cfg_i.scale > 3'(MAX_SCALE)) s_c = 3'(MAX_SCALE);
    else s_c = cfg_i.scale;
    // bit 3 of draw is the leftmost pixel, bits 7:6 of the byte
    for (int k = 0; k < 4; k++) begin
      sx            = (CW'(byte_q) << 2) + CW'(k);
      shade         = sprite_byte_i[7 - 2*k -: 2];
      draw[3 - k]   = (sx < w_c) && (shade != SBB_SHADE_CLEAR);
    end
    row_len = (w_c + CW'(3)) >> 2;
    byte_nx = CW'(byte_q) + CW'(1);
    row_nx  = CW'(row_q) + CW'(1);
  end

  // descriptor draw bits are indexed by pixel position, leftmost is 0
  always_comb begin
    q_desc_o.draw   = {draw[0], draw[1], draw[2], draw[3]};
    q_desc_o.shades = sprite_byte_i;
    q_desc_o.base_x = {cfg_i.origin_x[11], cfg_i.origin_x}
                      + ((13'(byte_q) << 2) * 13'(s_c));
    q_desc_o.base_y = {cfg_i.origin_y[11], cfg_i.origin_y}
                      + (13'(row_q) * 13'(s_c));
    q_desc_o.scale  = s_c;
  end

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;
  assign q_push_o   = accept && (|draw);

  always_comb begin
    byte_d = byte_q;
    row_d  = row_q;
    if (accept) begin
      if (byte_nx >= row_len) begin
        byte_d = '0;
        row_d  = (row_nx >= h_c) ? '0 : row_nx[RW-1:0];
      end else begin
        byte_d = byte_nx[BW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      byte_q <= '0;
    end else begin
      row_q  <= row_d;
      byte_q <= byte_d;
    end
  end

endmodule

FILE: design/sbb_fifo.sv
// ----------------------------------------------------------------------------
// sbb_fifo
// Short descriptor queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbb_fifo import sbb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  sbb_desc_t wdata_i,
  input  logic      pop_i,
  output sbb_desc_t rdata_o,
  output logic      empty_o,
  output logic      full_o
);

  localparam int PW = (SBB_QDEPTH > 1) ? $clog2(SBB_QDEPTH) : 1;
  localparam int NW = $clog2(SBB_QDEPTH + 1);

  sbb_desc_t     mem_q [SBB_QDEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [NW-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == NW'(SBB_QDEPTH));
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PW'(SBB_QDEPTH - 1)) ? '0 : wr_q + PW'(1);
    if (pop_i)  rd_d = (rd_q == PW'(SBB_QDEPTH - 1)) ? '0 : rd_q + PW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + NW'(1);
    else if (pop_i && !push_i) cnt_d = cnt_q - NW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= wdata_i;
  end

endmodule

FILE: design/sbb_back.sv
// ----------------------------------------------------------------------------
// sbb_back
// Walks each queued byte pixel by pixel and expands each drawn pixel into
// scale x scale writes, one a cycle while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbb_back import sbb_pkg::*; #(
  parameter int MAX_SCALE = SBB_MAX_SCALE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sbb_cfg_t           cfg_i,
  input  logic               q_empty_i,
  input  sbb_desc_t          q_desc_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [12:0] pix_x_o,
  output logic signed [12:0] pix_y_o,
  output logic [15:0]        color_o,
  output logic               last_of_run_o
);

  localparam int DW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  function automatic logic [2:0] next_pix(logic [3:0] draw, logic [2:0] from);
    logic [2:0] r;
    r = SBB_PIX_NONE;
    for (int i = 3; i >= 0; i--) begin
      if (draw[i] && (3'(i) >= from)) r = 3'(i);
    end
    return r;
  endfunction

  logic          busy_q, busy_d, out_valid_q, out_valid_d;
  sbb_desc_t     desc_q, desc_d;
  logic [1:0]    k_q, k_d;
  logic [DW-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [12:0]   x0_q, x0_d, x_q, x_d, y_q, y_d, nx_x, ld_x;
  logic [2:0]    nxt, first, s_last;
  logic [1:0]    shade;
  logic [15:0]   cur_color;
  logic          dx_last, dy_last, at_end, adv, load;
  logic signed [12:0] pix_x_q, pix_y_q;
  logic [15:0]   color_q;
  logic          last_q;

  assign s_last  = desc_q.scale - 3'd1;
  assign dx_last = (3'(dx_q) == s_last);
  assign dy_last = (3'(dy_q) == s_last);
  assign nxt     = next_pix(desc_q.draw, 3'(k_q) + 3'd1);
  assign first   = next_pix(q_desc_i.draw, 3'd0);
  assign nx_x    = desc_q.base_x + (13'(nxt[1:0]) * 13'(desc_q.scale));
  assign ld_x    = q_desc_i.base_x + (13'(first[1:0]) * 13'(q_desc_i.scale));
  assign at_end  = dx_last && dy_last && (nxt == SBB_PIX_NONE);
  assign adv     = busy_q && (!out_valid_q || !out_stall_i);
  assign load    = !q_empty_i && (!busy_q || (adv && at_end));
  assign q_pop_o = load;

  always_comb begin
    unique case (k_q)
      2'd0: shade = desc_q.shades[7:6];
      2'd1: shade = desc_q.shades[5:4];
      2'd2: shade = desc_q.shades[3:2];
      2'd3: shade = desc_q.shades[1:0];
    endcase
    unique case (shade)
      2'd0:    cur_color = cfg_i.color0;
      2'd1:    cur_color = cfg_i.color1;
      default: cur_color = cfg_i.color2;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    desc_d = desc_q;
    k_d    = k_q;
    dx_d   = dx_q;
    dy_d   = dy_q;
    x0_d   = x0_q;
    x_d    = x_q;
    y_d    = y_q;
    if (adv) begin
      if (!dx_last) begin
        dx_d = dx_q + DW'(1);
        x_d  = x_q + 13'd1;
      end else if (!dy_last) begin
        dx_d = '0;
        dy_d = dy_q + DW'(1);
        x_d  = x0_q;
        y_d  = y_q + 13'd1;
      end else if (nxt != SBB_PIX_NONE) begin
        k_d  = nxt[1:0];
        dx_d = '0;
        dy_d = '0;
        x0_d = nx_x;
        x_d  = nx_x;
        y_d  = desc_q.base_y;
      end else begin
        busy_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      desc_d = q_desc_i;
      k_d    = first[1:0];
      dx_d   = '0;
      dy_d   = '0;
      x0_d   = ld_x;
      x_d    = ld_x;
      y_d    = q_desc_i.base_y;
    end
    out_valid_d = adv || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    desc_q <= desc_d;
    k_q    <= k_d;
    dx_q   <= dx_d;
    dy_q   <= dy_d;
    x0_q   <= x0_d;
    x_q    <= x_d;
    y_q    <= y_d;
    if (adv) begin
      pix_x_q <= x_q;
      pix_y_q <= y_q;
      color_q <= cur_color;
      last_q  <= at_end;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pix_x_o       = pix_x_q;
  assign pix_y_o       = pix_y_q;
  assign color_o       = color_q;
  assign last_of_run_o = last_q;

endmodule

FILE: design/sprite_2bpp_scaled_blitter.sv
// ----------------------------------------------------------------------------
// sprite_2bpp_scaled_blitter
// Expands 2bpp sprite bytes into scaled pixel writes.
// ----------------------------------------------------------------------------
// Input channel: one sprite byte per item, row-major, in_valid_i/in_stall_o.
// Output channel: one pixel write per item (pix_x_o, pix_y_o, color_o,
// last_of_run_o), out_valid_o/out_stall_i; last_of_run_o marks the final
// write caused by a byte. Bytes whose pixels are all transparent or past the
// sprite width give no writes.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// always ready; write only while the block is idle.
// Path: a byte passes through the descriptor queue, the expander registers and the registered output stage.
// Throughput: one write per cycle from the expander while the output is not
// stalled; a byte gives drawn_pixels x scale x scale writes (4 at scale 1,
// full byte), and a two-entry queue lets bytes enter while earlier ones expand.
// Reset clears counters, queue and output; registers return to origin 0,
// size 16 x 16, scale 1, colours 0. A stalled output holds its write and the
// queue fills, after which in_stall_o is raised.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_2bpp_scaled_blitter import sbb_pkg::*; #(
  parameter int MAX_SIDE  = SBB_MAX_SIDE,
  parameter int MAX_SCALE = SBB_MAX_SCALE
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         sprite_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [12:0] pix_x_o,
  output logic signed [12:0] pix_y_o,
  output logic [15:0]        color_o,
  output logic               last_of_run_o
);

  sbb_cfg_t  cfg_q;
  sbb_desc_t push_desc, pop_desc;
  logic      q_push, q_pop, q_empty, q_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x      <= '0;
      cfg_q.origin_y      <= '0;
      cfg_q.sprite_width  <= 8'd16;
      cfg_q.sprite_height <= 8'd16;
      cfg_q.scale         <= 3'd1;
      cfg_q.color0        <= '0;
      cfg_q.color1        <= '0;
      cfg_q.color2        <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (sbb_reg_e'(cfg_index_i))
        REG_ORIGIN_X: cfg_q.origin_x      <= cfg_data_i[11:0];
        REG_ORIGIN_Y: cfg_q.origin_y      <= cfg_data_i[11:0];
        REG_WIDTH:    cfg_q.sprite_width  <= cfg_data_i[7:0];
        REG_HEIGHT:   cfg_q.sprite_height <= cfg_data_i[7:0];
        REG_SCALE:    cfg_q.scale         <= cfg_data_i[2:0];
        REG_COLOR0:   cfg_q.color0        <= cfg_data_i;
        REG_COLOR1:   cfg_q.color1        <= cfg_data_i;
        REG_COLOR2:   cfg_q.color2        <= cfg_data_i;
      endcase
    end
  end

  sbb_front #(
    .MAX_SIDE  (MAX_SIDE),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sprite_byte_i (sprite_byte_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_desc_o      (push_desc)
  );

  sbb_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (push_desc),
    .pop_i   (q_pop),
    .rdata_o (pop_desc),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  sbb_back #(
    .MAX_SCALE (MAX_SCALE)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_empty_i     (q_empty),
    .q_desc_i      (pop_desc),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pix_x_o       (pix_x_o),
    .pix_y_o       (pix_y_o),
    .color_o       (color_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

FILE: design/sbb_checker.sv
// ----------------------------------------------------------------------------
// sbb_checker
// Port-level checks of the sprite blitter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [12:0] pix_x_o,
  input logic signed [12:0] pix_y_o,
  input logic [15:0]        color_o,
  input logic               last_of_run_o
);

  // a stalled write holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pix_x_o)
      && $stable(pix_y_o) && $stable(color_o) && $stable(last_of_run_o))
    else $error("stalled pixel write changed");

  // writes of one byte follow without gaps
  a_run_dense: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o)
    else $error("gap inside a run of pixel writes");

  // nothing pending straight out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind sprite_2bpp_scaled_blitter sbb_checker u_sbb_checker (.*);

FILE: bench/sprite_2bpp_scaled_blitter_test.sv
// ----------------------------------------------------------------------------
// sprite_2bpp_scaled_blitter_test
// Self-checking bench for the 2bpp scaled sprite blitter: feeds sprite bytes
// under a series of register settings, predicts every pixel write from its
// own copy of the registers and row/byte counters, and compares each write
// as it leaves, with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sprite_2bpp_scaled_blitter_test;
  import sbb_pkg::*;

  localparam int PERIOD      = 12;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_TICKS = 10;

  typedef struct packed {
    logic signed [12:0] pix_x;
    logic signed [12:0] pix_y;
    logic [15:0]        color;
    logic               last;
  } pix_write_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i;
  logic [15:0]        cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [7:0]         sprite_byte_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [12:0] pix_x_o;
  logic signed [12:0] pix_y_o;
  logic [15:0]        color_o;
  logic               last_of_run_o;

  sprite_2bpp_scaled_blitter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sprite_byte_i (sprite_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pix_x_o       (pix_x_o),
    .pix_y_o       (pix_y_o),
    .color_o       (color_o),
    .last_of_run_o (last_of_run_o)
  );

  always #(PERIOD / 2) clk_i = ~clk_i;

  // bench copy of the registers and the source position
  sbb_cfg_t   cfg_shadow;
  logic [6:0] src_row;
  logic [4:0] src_byte;

  logic [7:0] byte_feed[$];
  pix_write_t due_writes[$];

  int  bytes_queued   = 0;
  int  bytes_taken    = 0;
  int  writes_checked = 0;
  int  mismatches     = 0;
  int  settings_used  = 1;
  int  cycle_count    = 0;
  bit  idle_on        = 1'b1;
  bit  byte_taken     = 1'b0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // all writes caused by one byte, then advance the source position
  task automatic expand_byte(input logic [7:0] sbyte);
    int         w, h, s, row_len, ox, oy, sx, px, py, k, dy, dx;
    logic [1:0] shade;
    logic [15:0] colour;
    pix_write_t held;
    bit         have_held;
    w = int'(cfg_shadow.sprite_width);
    if (w < 1) w = 1; else if (w > SBB_MAX_SIDE) w = SBB_MAX_SIDE;
    h = int'(cfg_shadow.sprite_height);
    if (h < 1) h = 1; else if (h > SBB_MAX_SIDE) h = SBB_MAX_SIDE;
    s = int'(cfg_shadow.scale);
    if (s < 1) s = 1; else if (s > SBB_MAX_SCALE) s = SBB_MAX_SCALE;
    row_len = (w + 3) / 4;
    ox = int'($signed(cfg_shadow.origin_x));
    oy = int'($signed(cfg_shadow.origin_y));
    have_held = 1'b0;
    held = '0;
    for (k = 0; k < 4; k++) begin
      sx = int'(src_byte) * 4 + k;
      shade = sbyte[(7 - 2 * k) -: 2];
      if (sx >= w || shade == SBB_SHADE_CLEAR) continue;
      case (shade)
        2'd0: colour = cfg_shadow.color0;
        2'd1: colour = cfg_shadow.color1;
        default: colour = cfg_shadow.color2;
      endcase
      for (dy = 0; dy < s; dy++) begin
        for (dx = 0; dx < s; dx++) begin
          if (have_held) due_writes.push_back(held);
          px = ox + sx * s + dx;
          py = oy + int'(src_row) * s + dy;
          held.pix_x = px[12:0];
          held.pix_y = py[12:0];
          held.color = colour;
          held.last  = 1'b0;
          have_held = 1'b1;
        end
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      due_writes.push_back(held);
    end
    if (int'(src_byte) + 1 >= row_len) begin
      src_byte = '0;
      if (int'(src_row) + 1 >= h) src_row = '0;
      else src_row = src_row + 1'b1;
    end else begin
      src_byte = src_byte + 1'b1;
    end
  endtask

  task automatic check_write();
    pix_write_t want;
    writes_checked++;
    if (due_writes.size() == 0) begin
      report_mismatch($sformatf("unexpected write x=%0d y=%0d colour=%h",
                                pix_x_o, pix_y_o, color_o));
      return;
    end
    want = due_writes.pop_front();
    if (pix_x_o !== want.pix_x)
      report_mismatch($sformatf("pix_x %0d, wanted %0d", pix_x_o, want.pix_x));
    if (pix_y_o !== want.pix_y)
      report_mismatch($sformatf("pix_y %0d, wanted %0d", pix_y_o, want.pix_y));
    if (color_o !== want.color)
      report_mismatch($sformatf("colour %h, wanted %h", color_o, want.color));
    if (last_of_run_o !== want.last)
      report_mismatch($sformatf("last_of_run %b, wanted %b", last_of_run_o, want.last));
  endtask

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      byte_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        expand_byte(sprite_byte_i);
        bytes_taken++;
      end
      if (out_valid_o && !out_stall_i) check_write();
    end
  end

  // item driver
  always @(negedge clk_i) begin
    if (!in_valid_i || byte_taken) begin
      if (byte_feed.size() != 0 && !(idle_on && $urandom_range(0, 99) < 24)) begin
        sprite_byte_i <= byte_feed.pop_front();
        in_valid_i    <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(0, 99) < 24);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sprite_2bpp_scaled_blitter regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input sbb_reg_e idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ORIGIN_X: cfg_shadow.origin_x      = data[11:0];
      REG_ORIGIN_Y: cfg_shadow.origin_y      = data[11:0];
      REG_WIDTH:    cfg_shadow.sprite_width  = data[7:0];
      REG_HEIGHT:   cfg_shadow.sprite_height = data[7:0];
      REG_SCALE:    cfg_shadow.scale         = data[2:0];
      REG_COLOR0:   cfg_shadow.color0        = data;
      REG_COLOR1:   cfg_shadow.color1        = data;
      default:      cfg_shadow.color2        = data;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    byte_feed.push_back(b);
    bytes_queued++;
  endtask

  task automatic wait_for_idle();
    do @(negedge clk_i); while (bytes_taken != bytes_queued || due_writes.size() != 0);
    repeat (DRAIN_TICKS) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // mostly small sprites, now and then the clamped extremes
  function automatic logic [15:0] pick_reg_value(input sbb_reg_e idx);
    logic [15:0] v;
    v = 16'($urandom);
    case (idx)
      REG_WIDTH: begin
        case ($urandom_range(0, 7))
          0: v[7:0] = 8'd0;
          1: v[7:0] = 8'($urandom_range(128, 255));
          default: v[7:0] = 8'($urandom_range(1, 24));
        endcase
      end
      REG_HEIGHT: begin
        case ($urandom_range(0, 7))
          0: v[7:0] = 8'd0;
          1: v[7:0] = 8'($urandom_range(128, 255));
          default: v[7:0] = 8'($urandom_range(1, 8));
        endcase
      end
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    int n_items, phase_no, random_bytes, r;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    sprite_byte_i = '0;
    out_stall_i   = 1'b0;
    cfg_shadow    = '{origin_x: '0, origin_y: '0, sprite_width: 8'd16,
                      sprite_height: 8'd16, scale: 3'd1,
                      color0: '0, color1: '0, color2: '0};
    src_row  = '0;
    src_byte = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: all shades, fully transparent byte
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h1B);
    queue_byte(8'hE4);
    queue_byte(8'hD8);
    wait_for_idle();

    // extreme origins, pad pixels dropped at width 5, scale 4
    write_reg(REG_ORIGIN_X, 16'hF800);
    write_reg(REG_ORIGIN_Y, 16'h07FF);
    write_reg(REG_WIDTH,    16'h0005);
    write_reg(REG_HEIGHT,   16'h0003);
    write_reg(REG_SCALE,    16'h0004);
    write_reg(REG_COLOR0,   16'hFFFF);
    write_reg(REG_COLOR1,   16'hA5A5);
    write_reg(REG_COLOR2,   16'h5A5A);
    end_writes();
    @(posedge clk_i);
    queue_byte(8'h1B);
    queue_byte(8'h3F);
    queue_byte(8'h00);
    queue_byte(8'hC0);
    queue_byte(8'hE4);
    queue_byte(8'h7F);
    queue_byte(8'hFF);
    wait_for_idle();

    // zero width, oversize height and zero scale clamp
    write_reg(REG_ORIGIN_X, 16'h07FF);
    write_reg(REG_WIDTH,    16'hFF00);
    write_reg(REG_HEIGHT,   16'h00FF);
    write_reg(REG_SCALE,    16'h0000);
    end_writes();
    @(posedge clk_i);
    queue_byte(8'h00);
    queue_byte(8'h40);
    queue_byte(8'hC0);
    wait_for_idle();

    // wide sprite part-way along a row, then the row shrinks under it
    write_reg(REG_WIDTH,  16'h0080);
    write_reg(REG_HEIGHT, 16'h0004);
    write_reg(REG_SCALE,  16'h0002);
    end_writes();
    @(posedge clk_i);
    queue_byte(8'h55);
    queue_byte(8'hAA);
    queue_byte(8'h12);
    queue_byte(8'h34);
    queue_byte(8'h56);
    wait_for_idle();
    write_reg(REG_WIDTH, 16'h0008);
    write_reg(REG_SCALE, 16'hFFF7);
    end_writes();
    @(posedge clk_i);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h1B);
    queue_byte(8'h2D);
    wait_for_idle();

    // random settings and sprite data
    random_bytes = 0;
    phase_no = 0;
    while (random_bytes < 340) begin
      for (r = 0; r < 8; r++) begin
        if (phase_no == 0 || $urandom_range(0, 1) == 1)
          write_reg(sbb_reg_e'(r), pick_reg_value(sbb_reg_e'(r)));
      end
      end_writes();
      idle_on = (phase_no != 2);
      n_items = (phase_no == 2) ? 60 : $urandom_range(20, 44);
      @(posedge clk_i);
      for (r = 0; r < n_items; r++) begin
        if ($urandom_range(0, 7) == 0) queue_byte(8'hFF);
        else queue_byte(8'($urandom_range(0, 255)));
      end
      random_bytes += n_items;
      wait_for_idle();
      idle_on = 1'b1;
      phase_no++;
    end

    $display("%0d sprite bytes fed under %0d register settings", bytes_taken, settings_used);
    $display("%0d pixel writes compared, %0d mismatches", writes_checked, mismatches);
    if (mismatches == 0) begin
      $display("sprite_2bpp_scaled_blitter regression: pass");
    end else begin
      $display("sprite_2bpp_scaled_blitter regression: fail");
    end
    $finish;
  end

endmodule
